FILE: sv/tps_pkg.sv
// Shared types and constants for the tower pump sequencer.
package tps_pkg;

  // Phase codes
  localparam logic [2:0] PH_INIT   = 3'd0;
  localparam logic [2:0] PH_SELECT = 3'd1;
  localparam logic [2:0] PH_ENABLE = 3'd2;
  localparam logic [2:0] PH_PUMP   = 3'd3;
  localparam logic [2:0] PH_FLOW   = 3'd4;
  localparam logic [2:0] PH_COOL   = 3'd5;
  localparam logic [2:0] PH_RUN    = 3'd6;
  localparam logic [2:0] PH_ERROR  = 3'd7;

  localparam logic [3:0] NO_TOWER    = 4'd15;
  localparam logic [3:0] ERROR_SHOWN = 4'd9;
  localparam int unsigned SECS_PER_MIN = 60;

  // floor(x / 15) == (x * DIV15_MAGIC) >> 35 for any 32-bit x
  localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;
  localparam int unsigned DIV15_SHIFT = 35;

  localparam int NUM_TOWERS_DEF  = 8;
  localparam int CLOCK_WIDTH_DEF = 32;

  // Register file
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;
  localparam logic [2:0] REG_TOWER_MASK = 3'd0;
  localparam logic [2:0] REG_NOWATER    = 3'd1;
  localparam logic [2:0] REG_COOLDOWN   = 3'd2;
  localparam logic [2:0] REG_MINUTES    = 3'd3;
  localparam logic [2:0] REG_RETRIES    = 3'd4;
  localparam logic [2:0] REG_FAILED     = 3'd5;

  localparam logic [15:0] NOWATER_RST  = 16'd60;
  localparam logic [15:0] COOLDOWN_RST = 16'd300;
  localparam logic [7:0]  RETRIES_RST  = 8'd3;
  localparam logic [6:0]  FAILED_RST   = 7'd3;

  typedef logic [2:0] phase_t;

  typedef struct packed {
    logic [7:0]  tower_mask;
    logic [15:0] nowater_limit;
    logic [15:0] cooldown_limit;
    logic [63:0] minutes_table;
    logic [7:0]  max_retries;
    logic [6:0]  max_failed;
  } cfg_t;

endpackage

FILE: sv/tps_if.sv
// Item channel interfaces for the tower pump sequencer.
interface tps_in_if;
  logic        valid;
  logic        ready;
  logic        run_enable;
  logic        pump_running;
  logic        flow_present;
  logic [31:0] time_seconds;

  modport source (output valid, run_enable, pump_running, flow_present, time_seconds,
                  input ready);
  modport sink (input valid, run_enable, pump_running, flow_present, time_seconds,
                output ready);
endinterface

interface tps_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tower_on_mask;
  logic        pump_on;
  logic        electrode_on;
  logic [3:0]  shown_tower;
  logic [26:0] run_minutes;
  logic [31:0] nowater_seconds;
  logic [31:0] cooldown_seconds;
  logic [2:0]  phase;

  modport source (output valid, tower_on_mask, pump_on, electrode_on, shown_tower,
                  run_minutes, nowater_seconds, cooldown_seconds, phase,
                  input ready);
  modport sink (input valid, tower_on_mask, pump_on, electrode_on, shown_tower,
                run_minutes, nowater_seconds, cooldown_seconds, phase,
                output ready);
endinterface

FILE: sv/tower_pump_sequencer_core.sv
// Top level of the tower pump sequencer: input stage, phase logic and result register.
//
//  channel  | direction | handshake           | contents
//  ---------+-----------+---------------------+-----------------------------------------
//  in_ch    | in        | valid / ready       | run_enable, pump/flow sensors, seconds
//  out_ch   | out       | valid / ready       | drives, shown tower, counters, phase
//  cfg      | in        | psel/penable/pready | six control registers at 8*i, 64-bit data
//
//  One item per cycle unless stalled; each item passes the input stage, then the phase registers.
//  The phase registers double as the result register and step only when the result slot
//  is empty or being drained, so a stalled result holds the phase and the input stage.
//  Rate is set by the single phase step: since-mark subtract, one 32x32 reciprocal multiply
//  for minutes, and the limit compares.
//  Reset is synchronous (rst_n low): phase init, no tower selected, drives off, no result.
module tower_pump_sequencer_core #(
  parameter int NUM_TOWERS  = tps_pkg::NUM_TOWERS_DEF,
  parameter int CLOCK_WIDTH = tps_pkg::CLOCK_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tps_in_if.sink                     in_ch,
  tps_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tps_pkg::CFG_AW-1:0] paddr,
  input  logic [tps_pkg::CFG_DW-1:0] pwdata,
  output logic [tps_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import tps_pkg::*;

  cfg_t cfg;

  tps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input stage
  logic                   s0_valid_r;
  logic                   run_r, pump_ok_r, flow_ok_r;
  logic [CLOCK_WIDTH-1:0] now_r;
  logic                   out_valid_r;
  logic                   adv;

  // Phase / result registers
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             tower_idx_r, tower_idx_nxt;
  logic [7:0]             retry_r, retry_nxt;
  logic [6:0]             failed_r, failed_nxt;
  logic [CLOCK_WIDTH-1:0] mark_r, mark_nxt;
  logic                   active_r, active_nxt;
  logic [7:0]             tower_drv_r, tower_drv_nxt;
  logic                   pump_drv_r, pump_drv_nxt;
  logic                   elec_drv_r, elec_drv_nxt;
  logic [3:0]             shown_r, shown_nxt;
  logic [26:0]            minutes_r, minutes_nxt;
  logic [31:0]            nowater_r, nowater_nxt;
  logic [31:0]            cooldown_r, cooldown_nxt;

  assign adv         = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || adv;

  // Hold the accepted item until the phase step takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      run_r     <= in_ch.run_enable;
      pump_ok_r <= in_ch.pump_running;
      flow_ok_r <= in_ch.flow_present;
      now_r     <= in_ch.time_seconds[CLOCK_WIDTH-1:0];
    end
  end

  // Result valid: set on a step, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Elapsed time since the mark, wrapping at the clock width
  logic [CLOCK_WIDTH-1:0] since;
  logic [31:0]            since32;
  logic [63:0]            min_prod;
  logic [26:0]            min_val;
  logic [7:0]             tbyte;
  logic [13:0]            run_thr;
  logic                   run_done;
  logic [7:0]             tbit;

  assign since    = now_r - mark_r;
  assign since32  = 32'(since);
  // minutes = since / 60 = (since / 4) / 15
  assign min_prod = 64'(since32 >> 2) * 64'(DIV15_MAGIC);
  assign min_val  = 27'(min_prod >> DIV15_SHIFT);
  // since / 60 >= limit  <=>  since >= 60 * limit
  assign tbyte    = cfg.minutes_table[8*tower_idx_r[2:0] +: 8];
  assign run_thr  = (14'(tbyte) << 6) - (14'(tbyte) << 2);
  assign run_done = since32 >= 32'(run_thr);
  assign tbit     = 8'd1 << tower_idx_r[2:0];

  // Upward scan from the tower after the current one, no wrap; a start past the last tower restarts at 0
  logic [3:0] scan_from;
  logic [4:0] scan_start;
  logic [7:0] scan_hit;
  logic [3:0] scan_idx;

  always_comb begin
    scan_from  = (phase_r == PH_INIT) ? NO_TOWER : tower_idx_r;
    scan_start = 5'(scan_from) + 5'd1;
    if (32'(scan_start) >= 32'(NUM_TOWERS)) begin
      scan_start = '0;
    end
    for (int i = 0; i < 8; i++) begin
      scan_hit[i] = cfg.tower_mask[i] && (i < NUM_TOWERS) && (5'(i) >= scan_start);
    end
    scan_idx = NO_TOWER;
    for (int i = 7; i >= 0; i--) begin
      if (scan_hit[i]) begin
        scan_idx = 4'(i);
      end
    end
  end

  // Phase step
  logic [31:0] flow_wait;
  logic [7:0]  retry_inc;
  logic [6:0]  failed_inc;

  always_comb begin
    phase_nxt     = phase_r;
    tower_idx_nxt = tower_idx_r;
    retry_nxt     = retry_r;
    failed_nxt    = failed_r;
    mark_nxt      = mark_r;
    active_nxt    = active_r;
    tower_drv_nxt = tower_drv_r;
    pump_drv_nxt  = pump_drv_r;
    elec_drv_nxt  = elec_drv_r;
    shown_nxt     = shown_r;
    minutes_nxt   = minutes_r;
    nowater_nxt   = nowater_r;
    cooldown_nxt  = cooldown_r;
    flow_wait     = flow_ok_r ? 32'd0 : since32;
    retry_inc     = retry_r + 8'd1;
    failed_inc    = failed_r + 7'd1;

    if (!run_r) begin
      // Leave run mode: back to init, drop drives once
      phase_nxt   = PH_INIT;
      shown_nxt   = '0;
      minutes_nxt = '0;
      if (active_r) begin
        tower_drv_nxt = '0;
        pump_drv_nxt  = 1'b0;
        elec_drv_nxt  = 1'b0;
        active_nxt    = 1'b0;
      end
    end else begin
      unique case (phase_r)
        PH_INIT, PH_SELECT: begin
          if (phase_r == PH_INIT) begin
            failed_nxt    = '0;
            mark_nxt      = '0;
            shown_nxt     = '0;
            minutes_nxt   = '0;
            nowater_nxt   = '0;
            cooldown_nxt  = '0;
            active_nxt    = 1'b1;
            tower_drv_nxt = '0;
            pump_drv_nxt  = 1'b0;
            elec_drv_nxt  = 1'b0;
            retry_nxt     = '0;
          end
          tower_idx_nxt = scan_idx;
          if (scan_idx != NO_TOWER) begin
            retry_nxt = '0;
            phase_nxt = PH_ENABLE;
          end else begin
            phase_nxt = PH_INIT;
          end
        end
        PH_ENABLE: begin
          phase_nxt     = PH_PUMP;
          tower_drv_nxt = tower_drv_r | tbit;
          pump_drv_nxt  = 1'b1;
          nowater_nxt   = '0;
          cooldown_nxt  = '0;
          minutes_nxt   = '0;
          shown_nxt     = tower_idx_r + 4'd1;
        end
        PH_PUMP: begin
          if (pump_ok_r) begin
            phase_nxt = PH_FLOW;
            mark_nxt  = now_r;
          end
        end
        PH_FLOW: begin
          if (flow_ok_r) begin
            phase_nxt  = PH_RUN;
            failed_nxt = '0;
            mark_nxt   = now_r;
          end
          nowater_nxt = flow_wait;
          // Timeout wins over flow when both land on this tick
          if (flow_wait >= 32'(cfg.nowater_limit)) begin
            phase_nxt    = PH_COOL;
            pump_drv_nxt = 1'b0;
            mark_nxt     = now_r;
          end
        end
        PH_COOL: begin
          cooldown_nxt = since32;
          if (since32 >= 32'(cfg.cooldown_limit)) begin
            retry_nxt = retry_inc;
            if (cfg.max_retries > retry_inc) begin
              phase_nxt     = PH_ENABLE;
              tower_drv_nxt = tower_drv_r & ~tbit;
            end else begin
              failed_nxt = failed_inc;
              if (cfg.max_failed > failed_inc) begin
                phase_nxt     = PH_SELECT;
                pump_drv_nxt  = 1'b0;
                tower_drv_nxt = tower_drv_r & ~tbit;
              end else begin
                phase_nxt = PH_ERROR;
              end
            end
          end
        end
        PH_RUN: begin
          minutes_nxt = min_val;
          if (run_done) begin
            phase_nxt     = PH_SELECT;
            pump_drv_nxt  = 1'b0;
            tower_drv_nxt = tower_drv_r & ~tbit;
          end
        end
        PH_ERROR: begin
          tower_drv_nxt = '0;
          pump_drv_nxt  = 1'b0;
          elec_drv_nxt  = 1'b1;
          shown_nxt     = ERROR_SHOWN;
        end
      endcase
    end
  end

  // Advance the phase registers with each stepped item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_INIT;
      tower_idx_r <= NO_TOWER;
      retry_r     <= '0;
      failed_r    <= '0;
      mark_r      <= '0;
      active_r    <= 1'b0;
      tower_drv_r <= '0;
      pump_drv_r  <= 1'b0;
      elec_drv_r  <= 1'b0;
      shown_r     <= '0;
      minutes_r   <= '0;
      nowater_r   <= '0;
      cooldown_r  <= '0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      tower_idx_r <= tower_idx_nxt;
      retry_r     <= retry_nxt;
      failed_r    <= failed_nxt;
      mark_r      <= mark_nxt;
      active_r    <= active_nxt;
      tower_drv_r <= tower_drv_nxt;
      pump_drv_r  <= pump_drv_nxt;
      elec_drv_r  <= elec_drv_nxt;
      shown_r     <= shown_nxt;
      minutes_r   <= minutes_nxt;
      nowater_r   <= nowater_nxt;
      cooldown_r  <= cooldown_nxt;
    end
  end

  // Result item straight from the phase registers
  assign out_ch.valid            = out_valid_r;
  assign out_ch.tower_on_mask    = tower_drv_r;
  assign out_ch.pump_on          = pump_drv_r;
  assign out_ch.electrode_on     = elec_drv_r;
  assign out_ch.shown_tower      = shown_r;
  assign out_ch.run_minutes      = minutes_r;
  assign out_ch.nowater_seconds  = nowater_r;
  assign out_ch.cooldown_seconds = cooldown_r;
  assign out_ch.phase            = phase_r;

endmodule

FILE: sv/tps_cfg_regs.sv
// APB-style configuration register file for the tower pump sequencer.
module tps_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tps_pkg::CFG_AW-1:0]  paddr,
  input  logic [tps_pkg::CFG_DW-1:0]  pwdata,
  output logic [tps_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output tps_pkg::cfg_t               cfg
);
  import tps_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  // Registers sit on 8-byte boundaries
  assign reg_idx = paddr[CFG_AW-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tower_mask     <= '0;
      cfg_r.nowater_limit  <= NOWATER_RST;
      cfg_r.cooldown_limit <= COOLDOWN_RST;
      cfg_r.minutes_table  <= '0;
      cfg_r.max_retries    <= RETRIES_RST;
      cfg_r.max_failed     <= FAILED_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TOWER_MASK: cfg_r.tower_mask     <= pwdata[7:0];
        REG_NOWATER:    cfg_r.nowater_limit  <= pwdata[15:0];
        REG_COOLDOWN:   cfg_r.cooldown_limit <= pwdata[15:0];
        REG_MINUTES:    cfg_r.minutes_table  <= pwdata;
        REG_RETRIES:    cfg_r.max_retries    <= pwdata[7:0];
        REG_FAILED:     cfg_r.max_failed     <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TOWER_MASK: prdata = CFG_DW'(cfg_r.tower_mask);
      REG_NOWATER:    prdata = CFG_DW'(cfg_r.nowater_limit);
      REG_COOLDOWN:   prdata = CFG_DW'(cfg_r.cooldown_limit);
      REG_MINUTES:    prdata = cfg_r.minutes_table;
      REG_RETRIES:    prdata = CFG_DW'(cfg_r.max_retries);
      REG_FAILED:     prdata = CFG_DW'(cfg_r.max_failed);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: sv/tps_checker.sv
// Port-level assertions for the tower pump sequencer, bound to the top level.
module tps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] tower_on_mask,
  input logic       pump_on,
  input logic       electrode_on,
  input logic [3:0] shown_tower,
  input logic [2:0] phase
);
  import tps_pkg::*;

  // Stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tower_on_mask) && $stable(phase)
      && $stable(shown_tower) && $stable(pump_on))
    else $error("result item changed while stalled");

  // Electrode only in error stop with everything else off
  a_elec_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && electrode_on |-> phase == PH_ERROR && shown_tower == ERROR_SHOWN
      && tower_on_mask == 8'd0 && !pump_on)
    else $error("electrode on outside error stop");

  // At most one valve, and never pump without a valve
  a_valves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(tower_on_mask) && (!pump_on || tower_on_mask != 8'd0))
    else $error("bad valve or pump drive");

  // Pump drive only while waiting on pump, waiting on flow, or running
  a_pump_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pump_on |-> phase == PH_PUMP || phase == PH_FLOW || phase == PH_RUN)
    else $error("pump on in wrong phase");

endmodule

bind tower_pump_sequencer_core tps_checker u_tps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .tower_on_mask (out_ch.tower_on_mask),
  .pump_on       (out_ch.pump_on),
  .electrode_on  (out_ch.electrode_on),
  .shown_tower   (out_ch.shown_tower),
  .phase         (out_ch.phase)
);
